// ----- hw/rtl/differential_drive_wheel_sync_unit_macros.svh -----
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DIFFERENTIAL_DRIVE_WHEEL_SYNC_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_WHEEL_SYNC_UNIT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/ddws_pkg.sv -----
// shared types and constants of the wheel sync unit
// no dependencies
package ddws_pkg;

  localparam int TARGET_BITS   = 23;
  localparam int MODE_BITS     = 2;
  localparam int DIST_BITS     = 10;
  localparam int REASON_BITS   = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 23;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TARGET = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_MODE   = 2'd2,
    CFG_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_FWD    = 2'd0,
    MODE_BWD    = 2'd1,
    MODE_TURN_R = 2'd2,
    MODE_TURN_L = 2'd3
  } move_mode_e;

  typedef enum logic [REASON_BITS-1:0] {
    RSN_RUN      = 3'd0,
    RSN_TARGET   = 3'd1,
    RSN_BUMPER   = 3'd2,
    RSN_OBSTACLE = 3'd3,
    RSN_IDLE     = 3'd4
  } stop_reason_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } ctl_state_e;

  typedef enum logic [1:0] {
    DV_IDLE = 2'd0,
    DV_MUL  = 2'd1,
    DV_RUN  = 2'd2
  } div_state_e;

endpackage

// ----- hw/rtl/ddws_if.sv -----
// valid/ready channels for input and result words
// depends on ddws_pkg
interface ddws_in_if import ddws_pkg::*; #(
  parameter int COUNT_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;
  logic                         left_bumper_hit;
  logic                         right_bumper_hit;
  logic [DIST_BITS-1:0]         obstacle_cm;

  modport source (
    output valid, cmd, left_count, right_count, left_bumper_hit, right_bumper_hit,
    output obstacle_cm,
    input  ready
  );
  modport sink (
    input  valid, cmd, left_count, right_count, left_bumper_hit, right_bumper_hit,
    input  obstacle_cm,
    output ready
  );
endinterface

interface ddws_out_if import ddws_pkg::*; #(
  parameter int SPEED_BITS = 15
);
  logic                   valid;
  logic                   ready;
  logic [SPEED_BITS-1:0]  left_speed;
  logic [SPEED_BITS-1:0]  right_speed;
  logic                   left_forward;
  logic                   right_forward;
  logic                   motors_stopped;
  logic [REASON_BITS-1:0] stop_reason;

  modport source (
    output valid, left_speed, right_speed, left_forward, right_forward,
    output motors_stopped, stop_reason,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, left_forward, right_forward,
    input  motors_stopped, stop_reason,
    output ready
  );
endinterface

// ----- hw/rtl/ddws_div.sv -----
// speed ratio unit: base * slow / fast, one multiply then restoring shift-subtract
// depends on ddws_pkg
module ddws_div import ddws_pkg::*; #(
  parameter int COUNT_BITS = 24,
  parameter int SPEED_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SPEED_BITS-1:0] base_i,
  input  logic [COUNT_BITS-1:0] num_i,
  input  logic [COUNT_BITS-1:0] den_i,
  output logic                  done_o,
  output logic [SPEED_BITS-1:0] quot_o
);

  localparam int PROD_BITS = COUNT_BITS + SPEED_BITS;
  localparam int CNT_BITS  = $clog2(SPEED_BITS);

  div_state_e            state_q, state_d;
  logic [SPEED_BITS-1:0] base_q;
  logic [COUNT_BITS-1:0] num_q;
  logic [COUNT_BITS-1:0] den_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [SPEED_BITS-1:0] quo_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  done_q;

  logic [PROD_BITS-1:0]  prod;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;
  logic [COUNT_BITS-1:0] rem_nxt;
  logic                  last;

  assign prod    = PROD_BITS'(base_q) * PROD_BITS'(num_q);
  // quotient is known to stay below 2^SPEED_BITS since num < den
  assign trial   = {rem_q, quo_q[SPEED_BITS-1]};
  assign diff    = trial - {1'b0, den_q};
  assign fits    = trial >= {1'b0, den_q};
  assign rem_nxt = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign last    = cnt_q == CNT_BITS'(SPEED_BITS - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: begin
        if (start_i) state_d = DV_MUL;
      end
      DV_MUL:  state_d = DV_RUN;
      DV_RUN: begin
        if (last) state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DV_RUN) && last;
      if (state_q == DV_MUL) begin
        cnt_q <= '0;
      end else if (state_q == DV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) begin
      base_q <= base_i;
      num_q  <= num_i;
      den_q  <= den_i;
    end
    if (state_q == DV_MUL) begin
      rem_q <= prod[PROD_BITS-1:SPEED_BITS];
      quo_q <= prod[SPEED_BITS-1:0];
    end else if (state_q == DV_RUN) begin
      rem_q <= rem_nxt;
      quo_q <= {quo_q[SPEED_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- hw/rtl/differential_drive_wheel_sync_unit.sv -----
// differential drive wheel sync unit: top level, uses ddws_pkg, ddws_if, ddws_div
// sequence: a running tick with unequal counts runs the multiply and the bit-serial divide
//   after accept, and its quotient is captured before the word enters the output register;
//   every other word goes from accept to the output register as soon as that register is free
// throughput: one word at a time, ready again when its result enters the output register
// reset: asynchronous active low, clears config registers, states, move flag and output valid
module differential_drive_wheel_sync_unit import ddws_pkg::*; #(
  parameter int COUNT_BITS = 24,
  parameter int SPEED_BITS = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  ddws_in_if.sink                  in_i,
  ddws_out_if.source               out_o
);

  localparam int CMP_BITS = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;

  logic [TARGET_BITS-1:0] target_q;
  logic [SPEED_BITS-1:0]  base_q;
  logic [MODE_BITS-1:0]   mode_q;
  logic [DIST_BITS-1:0]   limit_q;
  logic                   active_q;
  ctl_state_e             state_q, state_d;

  // captured result of the current word
  logic [SPEED_BITS-1:0]  res_lsp_q, res_rsp_q;
  logic                   res_lfwd_q, res_rfwd_q, res_stop_q, res_div_left_q;
  logic [REASON_BITS-1:0] res_reason_q;

  logic                   out_valid_q;
  logic [SPEED_BITS-1:0]  out_lsp_q, out_rsp_q;
  logic                   out_lfwd_q, out_rfwd_q, out_stop_q;
  logic [REASON_BITS-1:0] out_reason_q;

  logic                   in_ready, accept, out_free, out_load, div_start;
  logic                   turning, lfwd, rfwd, reached, bump, near;
  logic [COUNT_BITS-1:0]  lc, rc;
  logic                   dec_stop, dec_div, dec_div_left, dec_active;
  stop_reason_e           dec_reason;
  logic [SPEED_BITS-1:0]  dec_lsp, dec_rsp;
  logic [COUNT_BITS-1:0]  dec_num, dec_den;
  logic                   div_done;
  logic [SPEED_BITS-1:0]  div_quot;

  function automatic logic [COUNT_BITS-1:0] count_mag(input logic [COUNT_BITS-1:0] raw,
                                                      input logic turn);
    logic [COUNT_BITS-1:0] m;
    m = raw;
    // most negative value negates to itself, which is its magnitude as unsigned
    if (raw[COUNT_BITS-1]) m = turn ? (~raw + 1'b1) : '0;
    return m;
  endfunction

  assign turning  = mode_q[1];
  assign lfwd     = (mode_q == MODE_FWD) || (mode_q == MODE_TURN_R);
  assign rfwd     = (mode_q == MODE_FWD) || (mode_q == MODE_TURN_L);
  assign lc       = count_mag(in_i.left_count, turning);
  assign rc       = count_mag(in_i.right_count, turning);
  assign reached  = (CMP_BITS'(lc) >= CMP_BITS'(target_q)) &&
                    (CMP_BITS'(rc) >= CMP_BITS'(target_q));
  assign bump     = in_i.left_bumper_hit || in_i.right_bumper_hit;
  assign near     = (mode_q == MODE_FWD) && (in_i.obstacle_cm < limit_q);

  always_comb begin
    dec_stop     = 1'b1;
    dec_reason   = RSN_IDLE;
    dec_lsp      = '0;
    dec_rsp      = '0;
    dec_div      = 1'b0;
    dec_div_left = 1'b0;
    dec_num      = lc;
    dec_den      = rc;
    dec_active   = active_q;
    if (in_i.cmd == CMD_START) begin
      dec_active = 1'b1;
      dec_stop   = 1'b0;
      dec_reason = RSN_RUN;
    end else if (active_q) begin
      if (reached) begin
        dec_reason = RSN_TARGET;
      end else if (bump) begin
        dec_reason = RSN_BUMPER;
      end else if (near) begin
        dec_reason = RSN_OBSTACLE;
      end else begin
        dec_stop   = 1'b0;
        dec_reason = RSN_RUN;
        if (lc == rc) begin
          dec_lsp = base_q;
          dec_rsp = base_q;
        end else if (lc < rc) begin
          dec_lsp = base_q;
          dec_div = 1'b1;
        end else begin
          dec_rsp      = base_q;
          dec_div      = 1'b1;
          dec_div_left = 1'b1;
          dec_num      = rc;
          dec_den      = lc;
        end
      end
      if (dec_stop) dec_active = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = dec_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV:  in_ready = 1'b0;
      ST_DONE: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept    = in_i.valid && in_ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign div_start = accept && dec_div;

  ddws_div #(
    .COUNT_BITS(COUNT_BITS),
    .SPEED_BITS(SPEED_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .base_i (base_q),
    .num_i  (dec_num),
    .den_i  (dec_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      base_q      <= '0;
      mode_q      <= MODE_FWD;
      limit_q     <= '0;
      active_q    <= 1'b0;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TARGET: target_q <= cfg_data_i[TARGET_BITS-1:0];
          CFG_BASE:   base_q   <= cfg_data_i[SPEED_BITS-1:0];
          CFG_MODE:   mode_q   <= cfg_data_i[MODE_BITS-1:0];
          CFG_LIMIT:  limit_q  <= cfg_data_i[DIST_BITS-1:0];
          default:    ;
        endcase
      end
      if (accept) active_q <= dec_active;
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_lsp_q      <= dec_lsp;
      res_rsp_q      <= dec_rsp;
      res_lfwd_q     <= lfwd;
      res_rfwd_q     <= rfwd;
      res_stop_q     <= dec_stop;
      res_reason_q   <= dec_reason;
      res_div_left_q <= dec_div_left;
    end else if (state_q == ST_DIV && div_done) begin
      if (res_div_left_q) begin
        res_lsp_q <= div_quot;
      end else begin
        res_rsp_q <= div_quot;
      end
    end
    if (out_load) begin
      out_lsp_q    <= res_lsp_q;
      out_rsp_q    <= res_rsp_q;
      out_lfwd_q   <= res_lfwd_q;
      out_rfwd_q   <= res_rfwd_q;
      out_stop_q   <= res_stop_q;
      out_reason_q <= res_reason_q;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.left_speed     = out_lsp_q;
  assign out_o.right_speed    = out_rsp_q;
  assign out_o.left_forward   = out_lfwd_q;
  assign out_o.right_forward  = out_rfwd_q;
  assign out_o.motors_stopped = out_stop_q;
  assign out_o.stop_reason    = out_reason_q;

endmodule

// ----- hw/rtl/ddws_checker.sv -----
// port-level checks of the wheel sync unit, bound to the top level
// depends on ddws_pkg and the macros header
`include "differential_drive_wheel_sync_unit_macros.svh"

module ddws_checker import ddws_pkg::*; #(
  parameter int SPEED_BITS = 15
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SPEED_BITS-1:0]  left_speed_i,
  input logic [SPEED_BITS-1:0]  right_speed_i,
  input logic                   motors_stopped_i,
  input logic [REASON_BITS-1:0] stop_reason_i
);

  logic                                 speeds_zero;
  logic [2*SPEED_BITS+REASON_BITS-1:0]  out_word;

  assign speeds_zero = (left_speed_i == '0) && (right_speed_i == '0);
  assign out_word    = {left_speed_i, right_speed_i, stop_reason_i};

  // the unit is not ready in the cycle after taking a word
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // a stop word never carries a speed
  `ASSERT_IMPL(a_stop_zero_speed, out_valid_i && motors_stopped_i, speeds_zero)

  // stopped exactly when a stop reason is given
  `ASSERT_IMPL(a_stop_reason_match, out_valid_i, motors_stopped_i == (stop_reason_i != RSN_RUN))

  // result word holds while stalled
  `ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word))

endmodule

bind differential_drive_wheel_sync_unit ddws_checker #(
  .SPEED_BITS(SPEED_BITS)
) u_ddws_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .left_speed_i    (out_o.left_speed),
  .right_speed_i   (out_o.right_speed),
  .motors_stopped_i(out_o.motors_stopped),
  .stop_reason_i   (out_o.stop_reason)
);
